>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  // Command codes carried in the input kind field
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // Segment lengths in delay units
  localparam logic [3:0] UNITS_SHORT = 4'd1;
  localparam logic [3:0] UNITS_HIGH  = 4'd3;
  localparam logic [3:0] UNITS_EDGE  = 4'd6;
  localparam logic [3:0] UNITS_TAIL  = 4'd12;

  localparam int unsigned OUT_W = 16;

  // One result transaction
  typedef struct packed {
    logic       slave_nack;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_level;
  } res_t;

endpackage

>>> rtl/core/i2cm_out_reg.sv
`include "assert_macros.svh"

module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  res_t             res,
  output logic             in_ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic valid_r;
  res_t data_r;

  // Take a new result when the register is empty or being drained
  assign in_ready   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_W - $bits(res_t)){1'b0}}, data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Hold payload until a new transaction replaces it
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  `ASSERT_NEVER(a_no_overwrite, clk, rst_n, load && valid_r && !out_tready)
  `ASSERT_AT(a_load_shows, clk, rst_n, load |=> valid_r)

endmodule

>>> rtl/core/i2c_master_byte_engine.sv
// I2C master byte engine. Each input transaction is one tick of the bus
// timer and yields exactly one result transaction with the SCL/SDA levels,
// busy, a one-tick done pulse, the last received byte and the acknowledge
// error. While idle, the kind field starts a start, stop, write-byte or
// read-byte operation; while busy, commands are ignored. Throughput is one
// transaction per clock unless stalled: the per-tick update is a single
// 17-bit increment and compare on the tick counter plus the segment
// sequencer, all between the state registers and the result register, so
// each result is offered the next cycle. Phase lengths are 1, 3, 6 or 12
// delay units of cfg_wr_data ticks each (a value of zero acts as one). A new
// unit length applies from the next tick on, also in the middle of an
// operation: a running unit whose count has reached or passed it ends there.
`include "assert_macros.svh"

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // Input stream: tdata = tx_byte[7:0], ack_level[8], sda_in[9], zero pad
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,
  // tuser = kind[2:0]
  input  logic [2:0]       in_tuser,
  // Result stream: tdata = scl_level[0], sda_release[1], busy_res[2],
  // done_res[3], rx_byte[11:4], slave_nack[12], zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  // Unit length register
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ST_A     = 4'd1,
    PH_ST_B     = 4'd2,
    PH_ST_C     = 4'd3,
    PH_SP_A     = 4'd4,
    PH_SP_B     = 4'd5,
    PH_SP_C     = 4'd6,
    PH_WR_SET   = 4'd7,
    PH_WR_HIGH  = 4'd8,
    PH_WR_LOW   = 4'd9,
    PH_WR_ACK   = 4'd10,
    PH_TAIL     = 4'd11,
    PH_RD_HIGH  = 4'd12,
    PH_RD_LOW   = 4'd13,
    PH_RD_ASET  = 4'd14,
    PH_RD_AHIGH = 4'd15
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [3:0]  unit_count_r, unit_count_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        slave_nack_r, slave_nack_nxt;
  logic        ack_to_send_r, ack_to_send_nxt;
  logic [7:0]  rx_last_r, rx_last_nxt;
  logic [15:0] unit_ticks_r;

  logic        in_fire;
  logic        done_nxt;
  logic        entered;
  logic [15:0] lim;
  logic [16:0] tick_inc;
  logic        tx_bit;
  res_t        res;

  logic [2:0]  kind;
  logic [7:0]  tx_byte;
  logic        ack_level;
  logic        sda_in;

  assign kind      = in_tuser;
  assign tx_byte   = in_tdata[7:0];
  assign ack_level = in_tdata[8];
  assign sda_in    = in_tdata[9];
  assign in_fire   = in_tvalid && in_tready;

  // Units that make up each segment
  function automatic logic [3:0] seg_units(phase_t p);
    logic [3:0] u;
    unique case (p)
      PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B, PH_SP_C: u = UNITS_EDGE;
      PH_WR_HIGH, PH_RD_HIGH, PH_RD_AHIGH:                  u = UNITS_HIGH;
      PH_TAIL:                                              u = UNITS_TAIL;
      PH_IDLE:                                              u = 4'd0;
      default:                                              u = UNITS_SHORT;
    endcase
    return u;
  endfunction

  // Advance the bus sequencer by one tick
  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    unit_count_nxt  = unit_count_r;
    bit_index_nxt   = bit_index_r;
    shift_byte_nxt  = shift_byte_r;
    scl_nxt         = scl_r;
    sda_nxt         = sda_r;
    slave_nack_nxt  = slave_nack_r;
    ack_to_send_nxt = ack_to_send_r;
    rx_last_nxt     = rx_last_r;
    done_nxt        = 1'b0;
    entered         = 1'b0;
    lim             = (unit_ticks_r == 16'd0) ? 16'd1 : unit_ticks_r;
    tick_inc        = {1'b0, tick_count_r} + 17'd1;

    if (phase_r == PH_IDLE) begin
      bit_index_nxt = 4'd0;
      case (kind)
        KIND_START: begin
          phase_nxt = PH_ST_A;
          entered   = 1'b1;
        end
        KIND_STOP: begin
          phase_nxt = PH_SP_A;
          entered   = 1'b1;
        end
        KIND_WRITE: begin
          shift_byte_nxt = tx_byte;
          phase_nxt      = PH_WR_SET;
          entered        = 1'b1;
        end
        KIND_READ: begin
          shift_byte_nxt  = 8'd0;
          ack_to_send_nxt = ack_level;
          phase_nxt       = PH_RD_HIGH;
          entered         = 1'b1;
        end
        default: ;
      endcase
    end else if (tick_inc >= {1'b0, lim}) begin
      tick_count_nxt = 16'd0;
      unit_count_nxt = unit_count_r + 4'd1;
      if (unit_count_nxt >= seg_units(phase_r)) begin
        entered = 1'b1;
        unique case (phase_r)
          PH_ST_A:    phase_nxt = PH_ST_B;
          PH_ST_B:    phase_nxt = PH_ST_C;
          PH_SP_A:    phase_nxt = PH_SP_B;
          PH_SP_B:    phase_nxt = PH_SP_C;
          PH_WR_SET:  phase_nxt = PH_WR_HIGH;
          PH_WR_HIGH: phase_nxt = PH_WR_LOW;
          PH_WR_LOW: begin
            bit_index_nxt = bit_index_r + 4'd1;
            phase_nxt     = (bit_index_nxt >= 4'd8) ? PH_WR_ACK : PH_WR_SET;
          end
          PH_WR_ACK: begin
            slave_nack_nxt = sda_in;
            phase_nxt      = PH_TAIL;
          end
          PH_RD_HIGH: begin
            shift_byte_nxt = {shift_byte_r[6:0], sda_in};
            phase_nxt      = PH_RD_LOW;
          end
          PH_RD_LOW: begin
            bit_index_nxt = bit_index_r + 4'd1;
            phase_nxt     = (bit_index_nxt >= 4'd8) ? PH_RD_ASET : PH_RD_HIGH;
          end
          PH_RD_ASET: phase_nxt = PH_RD_AHIGH;
          PH_RD_AHIGH: begin
            rx_last_nxt = shift_byte_r;
            phase_nxt   = PH_TAIL;
          end
          default: begin
            // End of start, stop or tail: back to idle
            entered   = 1'b0;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
        endcase
        unit_count_nxt = 4'd0;
      end
    end else begin
      tick_count_nxt = tick_inc[15:0];
    end

    // Entering a segment clears the counters and sets its line levels
    tx_bit = shift_byte_nxt[3'd7 - bit_index_nxt[2:0]];
    if (entered) begin
      tick_count_nxt = 16'd0;
      unit_count_nxt = 4'd0;
      unique case (phase_nxt)
        PH_ST_A, PH_SP_C, PH_WR_ACK, PH_RD_HIGH: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        PH_ST_B, PH_SP_B: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        PH_ST_C, PH_SP_A: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        PH_WR_SET, PH_WR_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = tx_bit;
        end
        PH_WR_HIGH: begin
          scl_nxt = 1'b1;
          sda_nxt = tx_bit;
        end
        PH_TAIL, PH_RD_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        PH_RD_ASET: begin
          scl_nxt = 1'b0;
          sda_nxt = ack_to_send_r;
        end
        PH_RD_AHIGH: begin
          scl_nxt = 1'b1;
          sda_nxt = ack_to_send_r;
        end
        default: ;
      endcase
    end
  end

  // Assemble the result of this tick
  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_release = sda_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done_nxt;
    res.rx_byte     = rx_last_nxt;
    res.slave_nack  = slave_nack_nxt;
  end

  // Hold sequencer state, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= 16'd0;
      unit_count_r  <= 4'd0;
      bit_index_r   <= 4'd0;
      shift_byte_r  <= 8'd0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      slave_nack_r  <= 1'b0;
      ack_to_send_r <= 1'b0;
      rx_last_r     <= 8'd0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      unit_count_r  <= unit_count_nxt;
      bit_index_r   <= bit_index_nxt;
      shift_byte_r  <= shift_byte_nxt;
      scl_r         <= scl_nxt;
      sda_r         <= sda_nxt;
      slave_nack_r  <= slave_nack_nxt;
      ack_to_send_r <= ack_to_send_nxt;
      rx_last_r     <= rx_last_nxt;
    end
  end

  // Unit length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= 16'd16;
    end else if (cfg_wr_en) begin
      unit_ticks_r <= cfg_wr_data;
    end
  end

  i2cm_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .res        (res),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `ASSERT_AT(a_done_idle, clk, rst_n, (in_fire && done_nxt) |=> (phase_r == PH_IDLE))
  `ASSERT_AT(a_bit_index_range, clk, rst_n, bit_index_r <= 4'd8)
  `ASSERT_AT(a_idle_counters, clk, rst_n,
    (phase_r == PH_IDLE) |-> (tick_count_r == 16'd0 && unit_count_r == 4'd0))

endmodule
